FILE: hdl/cuc_time_code_decoder_defines.svh
// assertion macros shared by the time code decoder modules
`ifndef CUC_TIME_CODE_DECODER_DEFINES_SVH
`define CUC_TIME_CODE_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CUC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CUC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cuc_pkg.sv
// types and constants of the time code decoder
package cuc_pkg;

    typedef struct packed {
        logic       external_code_valid;
        logic [7:0] external_code;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
    } cuc_in_t;

    typedef struct packed {
        logic [31:0] seconds;
        logic [19:0] microseconds;
        logic [1:0]  status;
    } cuc_out_t;

    // classified code handed from the front to the back
    typedef struct packed {
        logic [1:0]  status;
        logic        level2;
        logic [1:0]  nfine;
        logic [31:0] coarse;
        logic [23:0] fine;
    } cuc_entry_t;

    typedef struct packed {
        logic [31:0] tai_epoch_offset;
        logic [31:0] mission_epoch_offset;
    } cuc_cfg_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic CFG_TAI_EPOCH     = 1'b0;
    localparam logic CFG_MISSION_EPOCH = 1'b1;

    localparam logic [31:0] TAI_EPOCH_RESET     = 32'hE96D_A180; // -378691200
    localparam logic [31:0] MISSION_EPOCH_RESET = 32'h0000_0000;

    // p-field bits 6..2 for 4 coarse octets
    localparam logic [4:0] PF_LEVEL1 = 5'b00111;
    localparam logic [4:0] PF_LEVEL2 = 5'b01011;

    // 10^6 / 2^6, fine scale before the per-length shift
    localparam logic [13:0] FINE_SCALE = 14'd15625;
    localparam int unsigned PROD_W = 38;

endpackage

FILE: hdl/cuc_time_code_decoder.sv
// top level of the unsegmented time code decoder
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  command  | start, busy                | item (cuc_in_t)
//  result   | result_valid (strobe)      | result (cuc_out_t)
//  config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
//  one code per cycle while busy is low; the result strobe follows the accepting edge through
//  the front register, queue slot, multiply stage and result register
//  the 24x14 fine-time multiply is the deepest path and has a stage of its own
//  rst_n clears the control state and loads the reset epoch offsets
//  the back pops the queue whenever it is not empty, so it holds at most one code and busy
//  stays low for a queue depth of three or more; results cannot be held off
module cuc_time_code_decoder #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cuc_pkg::cuc_in_t  item,
    output logic              result_valid,
    output cuc_pkg::cuc_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data
);

    cuc_pkg::cuc_cfg_t   cfg_reg;
    cuc_pkg::cuc_entry_t front_entry, queue_head;
    logic                front_valid, queue_not_empty, queue_almost_full;
    logic                accept;

    assign busy      = queue_almost_full;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tai_epoch_offset     <= cuc_pkg::TAI_EPOCH_RESET;
            cfg_reg.mission_epoch_offset <= cuc_pkg::MISSION_EPOCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cuc_pkg::CFG_TAI_EPOCH:     cfg_reg.tai_epoch_offset     <= cfg_data;
                cuc_pkg::CFG_MISSION_EPOCH: cfg_reg.mission_epoch_offset <= cfg_data;
                default: ;
            endcase
        end
    end

    cuc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .entry       (front_entry),
        .entry_valid (front_valid)
    );

    cuc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (front_valid),
        .push_entry  (front_entry),
        .pop         (queue_not_empty),
        .head        (queue_head),
        .not_empty   (queue_not_empty),
        .almost_full (queue_almost_full)
    );

    cuc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (queue_not_empty),
        .entry        (queue_head),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: hdl/cuc_front.sv
// front stage: p-field check, classification and field extraction
module cuc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  cuc_pkg::cuc_in_t    item,
    output cuc_pkg::cuc_entry_t entry,
    output logic                entry_valid
);

    cuc_pkg::cuc_entry_t entry_reg, entry_next;
    logic                valid_reg;
    logic [7:0]          pf;
    logic                ext_bare;
    logic [7:0]          c0, c1, c2, c3, f0, f1, f2;

    always_comb
    begin
        // external p-field with bit 7 set means the buffer has no p-field byte
        ext_bare = item.external_code_valid & item.external_code[7];
        pf       = ext_bare ? {1'b0, item.external_code[6:0]} : item.byte_0;
        if (ext_bare)
        begin
            c0 = item.byte_0; c1 = item.byte_1; c2 = item.byte_2; c3 = item.byte_3;
            f0 = item.byte_4; f1 = item.byte_5; f2 = item.byte_6;
        end
        else
        begin
            c0 = item.byte_1; c1 = item.byte_2; c2 = item.byte_3; c3 = item.byte_4;
            f0 = item.byte_5; f1 = item.byte_6; f2 = item.byte_7;
        end

        entry_next.nfine  = pf[1:0];
        entry_next.level2 = (pf[6:2] == cuc_pkg::PF_LEVEL2);
        entry_next.coarse = {c0, c1, c2, c3};
        case (pf[1:0])
            2'd0:    entry_next.fine = 24'd0;
            2'd1:    entry_next.fine = {16'd0, f0};
            2'd2:    entry_next.fine = {8'd0, f0, f1};
            default: entry_next.fine = {f0, f1, f2};
        endcase

        if (item.external_code_valid && !item.external_code[7]
            && item.external_code != item.byte_0)
            entry_next.status = cuc_pkg::STATUS_MISMATCH;
        else if (pf[7] || (pf[6:2] != cuc_pkg::PF_LEVEL1 && pf[6:2] != cuc_pkg::PF_LEVEL2))
            entry_next.status = cuc_pkg::STATUS_INVALID;
        else
            entry_next.status = cuc_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg <= entry_next;
    end

    assign entry       = entry_reg;
    assign entry_valid = valid_reg;

endmodule

FILE: hdl/cuc_fifo.sv
// short queue of classified codes between front and back
`include "cuc_time_code_decoder_defines.svh"
module cuc_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cuc_pkg::cuc_entry_t push_entry,
    input  logic                pop,
    output cuc_pkg::cuc_entry_t head,
    output logic                not_empty,
    output logic                almost_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cuc_pkg::cuc_entry_t slots [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign do_pop  = pop && (count_reg != '0);
    assign do_push = push && (count_reg != CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

    assign head        = slots[rd_ptr_reg];
    assign not_empty   = (count_reg != '0);
    // leaves room for the transaction still in the front register
    assign almost_full = (count_reg >= CNT_W'(DEPTH - 1));

    `CUC_ASSERT_NOW(a_no_overflow, push, count_reg != CNT_W'(DEPTH), "push into full queue")
    `CUC_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count out of range")
    `CUC_ASSERT_NEXT(a_count_track, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not follow push")

endmodule

FILE: hdl/cuc_back.sv
// back stages: fine-time scaling, epoch offset and result register
`include "cuc_time_code_decoder_defines.svh"
module cuc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                entry_valid,
    input  cuc_pkg::cuc_entry_t entry,
    input  cuc_pkg::cuc_cfg_t   cfg,
    output logic                result_valid,
    output cuc_pkg::cuc_out_t   result
);

    localparam int unsigned PW = cuc_pkg::PROD_W;

    logic                s1_valid_reg;
    cuc_pkg::cuc_entry_t s1_entry_reg;
    logic [PW-1:0]       s1_prod_reg, s1_prod_next;
    logic                out_valid_reg;
    cuc_pkg::cuc_out_t   out_reg, out_next;
    logic [19:0]         micro;

    assign s1_prod_next = PW'(entry.fine) * PW'(cuc_pkg::FINE_SCALE);

    always_comb
    begin
        // shift by 8n-6 for n fine octets
        case (s1_entry_reg.nfine)
            2'd0:    micro = 20'd0;
            2'd1:    micro = s1_prod_reg[21:2];
            2'd2:    micro = s1_prod_reg[29:10];
            default: micro = s1_prod_reg[37:18];
        endcase
        if (s1_entry_reg.status == cuc_pkg::STATUS_OK)
        begin
            out_next.seconds = s1_entry_reg.coarse + (s1_entry_reg.level2 ?
                cfg.mission_epoch_offset : cfg.tai_epoch_offset);
            out_next.microseconds = micro;
        end
        else
        begin
            out_next.seconds      = 32'd0;
            out_next.microseconds = 20'd0;
        end
        out_next.status = s1_entry_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= entry_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_valid)
        begin
            s1_entry_reg <= entry;
            s1_prod_reg  <= s1_prod_next;
        end
        if (s1_valid_reg)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `CUC_ASSERT_NEXT(a_stage_flow, s1_valid_reg, result_valid, "scaled code did not reach result")
    `CUC_ASSERT_NOW(a_error_zero, result_valid && result.status != cuc_pkg::STATUS_OK,
        result.seconds == 32'd0 && result.microseconds == 20'd0, "error result carries time")
    `CUC_ASSERT_NOW(a_status_code, result_valid,
        result.status == cuc_pkg::STATUS_OK || result.status == cuc_pkg::STATUS_INVALID
        || result.status == cuc_pkg::STATUS_MISMATCH, "result status has no meaning")

endmodule

FILE: tb/tb_cuc_time_code_decoder.sv
// self-checking testbench for the unsegmented time code decoder
`timescale 1ns / 100ps

module tb_cuc_time_code_decoder;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 290;
    localparam int unsigned NUM_PHASES = 5;

    typedef struct packed {
        cuc_pkg::cuc_in_t  stim;
        logic              typed;
        cuc_pkg::cuc_out_t want;
    } dir_row_t;

    localparam cuc_pkg::cuc_out_t NO_WANT = '0;

    // stim = {external_code_valid, external_code, byte_0 .. byte_7}
    localparam dir_row_t DIR_ROWS [0:23] = '{
        '{{1'b0, 8'h00, 64'h1C00_0000_0000_0000}, 1'b1,
          {32'hE96D_A180, 20'd0, cuc_pkg::STATUS_OK}},
        '{{1'b0, 8'h00, 64'h2CFF_FFFF_FF00_0000}, 1'b1,
          {32'hFFFF_FFFF, 20'd0, cuc_pkg::STATUS_OK}},
        '{{1'b0, 8'h00, 64'h2D00_0000_00FF_0000}, 1'b1,
          {32'h0, 20'd996093, cuc_pkg::STATUS_OK}},
        '{{1'b0, 8'h00, 64'h2E00_0000_00FF_FF00}, 1'b1,
          {32'h0, 20'd999984, cuc_pkg::STATUS_OK}},
        '{{1'b0, 8'h00, 64'h2F00_0000_00FF_FFFF}, 1'b1,
          {32'h0, 20'd999999, cuc_pkg::STATUS_OK}},
        '{{1'b0, 8'h00, 64'h1FFF_FFFF_FF12_3456}, 1'b0, NO_WANT},
        '{{1'b1, 8'h9C, 64'h0102_0304_AABB_CCDD}, 1'b0, NO_WANT},
        '{{1'b1, 8'hAF, 64'hFFFF_FFFF_FFFF_FF00}, 1'b1,
          {32'hFFFF_FFFF, 20'd999999, cuc_pkg::STATUS_OK}},
        '{{1'b1, 8'h2D, 64'h2D80_0000_0180_5A5A}, 1'b0, NO_WANT},
        '{{1'b1, 8'h1C, 64'h1D00_0000_0000_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_MISMATCH}},
        '{{1'b1, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_MISMATCH}},
        '{{1'b0, 8'h00, 64'h9C00_0000_0000_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        '{{1'b0, 8'h00, 64'h3C12_3456_7800_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        '{{1'b0, 8'h9C, 64'h0000_0000_0000_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        '{{1'b1, 8'hFF, 64'h1C00_0000_0000_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        '{{1'b1, 8'h80, 64'h1C00_0000_0000_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        '{{1'b1, 8'h1C, 64'h1C00_0000_2A00_0000}, 1'b0, NO_WANT},
        '{{1'b0, 8'h5A, 64'h1E12_3456_789A_BCDE}, 1'b0, NO_WANT},
        '{{1'b1, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        '{{1'b0, 8'h00, 64'h0000_0000_0000_0000}, 1'b1,
          {32'h0, 20'd0, cuc_pkg::STATUS_INVALID}},
        // bytes past the code are ignored
        '{{1'b0, 8'h00, 64'h1C00_0000_00FF_FFFF}, 1'b1,
          {32'hE96D_A180, 20'd0, cuc_pkg::STATUS_OK}},
        '{{1'b1, 8'hAD, 64'h7FFF_FFFF_8000_0000}, 1'b1,
          {32'h7FFF_FFFF, 20'd500000, cuc_pkg::STATUS_OK}},
        '{{1'b1, 8'h9E, 64'h8000_0000_FFFF_1234}, 1'b0, NO_WANT},
        '{{1'b1, 8'h2C, 64'h2C12_3456_789A_BCDE}, 1'b0, NO_WANT}
    };

    localparam int unsigned IDLE_PCT [NUM_PHASES] = '{0, 86, 12, 0, 50};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    cuc_pkg::cuc_in_t  item = '0;
    logic              result_valid;
    cuc_pkg::cuc_out_t result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = cuc_pkg::CFG_TAI_EPOCH;
    logic [31:0]       cfg_data = '0;

    logic [31:0]       tai_offset = cuc_pkg::TAI_EPOCH_RESET;
    logic [31:0]       mission_offset = cuc_pkg::MISSION_EPOCH_RESET;
    cuc_pkg::cuc_out_t pending_times [$];

    int unsigned fail_count = 0;
    int unsigned codes_sent = 0;
    int unsigned times_checked = 0;
    int unsigned epoch_writes = 0;
    int unsigned n_ok = 0;
    int unsigned n_invalid = 0;
    int unsigned n_mismatch = 0;
    int unsigned stall_cycles = 0;

    cuc_time_code_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic cuc_pkg::cuc_out_t decode_time_code(cuc_pkg::cuc_in_t x);
        cuc_pkg::cuc_out_t r;
        logic [7:0]        oct [8];
        logic [7:0]        pf;
        int unsigned       base;
        int unsigned       nfine;
        logic              lvl2;
        logic [31:0]       coarse;
        logic [63:0]       fine;
        r = '0;
        r.status = cuc_pkg::STATUS_OK;
        oct[0] = x.byte_0;
        oct[1] = x.byte_1;
        oct[2] = x.byte_2;
        oct[3] = x.byte_3;
        oct[4] = x.byte_4;
        oct[5] = x.byte_5;
        oct[6] = x.byte_6;
        oct[7] = x.byte_7;
        if (x.external_code_valid && !x.external_code[7] && x.external_code != x.byte_0)
        begin
            r.status = cuc_pkg::STATUS_MISMATCH;
            return r;
        end
        if (x.external_code_valid && x.external_code[7])
        begin
            pf = {1'b0, x.external_code[6:0]};
            base = 0;
        end
        else
        begin
            pf = x.byte_0;
            base = 1;
        end
        if (pf[7])
        begin
            r.status = cuc_pkg::STATUS_INVALID;
            return r;
        end
        if (pf[6:2] == cuc_pkg::PF_LEVEL1)
            lvl2 = 1'b0;
        else if (pf[6:2] == cuc_pkg::PF_LEVEL2)
            lvl2 = 1'b1;
        else
        begin
            r.status = cuc_pkg::STATUS_INVALID;
            return r;
        end
        nfine = 32'(pf[1:0]);
        coarse = {oct[base], oct[base + 1], oct[base + 2], oct[base + 3]};
        fine = '0;
        for (int i = 0; i < nfine; i++)
            fine = {fine[55:0], oct[base + 4 + i]};
        if (nfine != 0)
            r.microseconds = 20'((fine * 64'(cuc_pkg::FINE_SCALE)) >> (8 * nfine - 6));
        r.seconds = coarse + (lvl2 ? mission_offset : tai_offset);
        return r;
    endfunction

    function automatic logic [7:0] rand_octet();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // mostly well-formed codes with random content, the rest broken or noise
    function automatic cuc_pkg::cuc_in_t rand_time_code();
        cuc_pkg::cuc_in_t x;
        int unsigned      kind;
        int unsigned      fill;
        logic [7:0]       pf;
        fill = $urandom_range(0, 15);
        x.external_code_valid = 1'($urandom);
        x.external_code = 8'($urandom);
        x.byte_0 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_1 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_2 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_3 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_4 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_5 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_6 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        x.byte_7 = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : rand_octet();
        pf = {1'b0, ($urandom_range(0, 1) ? cuc_pkg::PF_LEVEL2 : cuc_pkg::PF_LEVEL1),
              2'($urandom)};
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            x.external_code_valid = 1'b0;
            x.byte_0 = pf;
        end
        else if (kind < 55)
        begin
            x.external_code_valid = 1'b1;
            x.external_code = pf;
            x.byte_0 = pf;
        end
        else if (kind < 80)
        begin
            x.external_code_valid = 1'b1;
            x.external_code = pf | 8'h80;
        end
        else if (kind < 88)
        begin
            // p-field disagreeing with the buffer
            x.external_code_valid = 1'b1;
            x.external_code = $urandom_range(0, 1) ? pf : {1'b0, x.external_code[6:0]};
            if (x.byte_0 == x.external_code)
                x.byte_0 = x.byte_0 ^ (8'h01 << $urandom_range(0, 7));
        end
        return x;
    endfunction

    // start stays high for back-to-back codes; idle_gap lowers it
    // busy is looked at mid-cycle, where it holds its value for the coming edge
    task automatic issue_code(input cuc_pkg::cuc_in_t x, input logic typed,
                              input cuc_pkg::cuc_out_t want);
        logic held;
        start <= 1'b1;
        item <= x;
        do
        begin
            @(negedge clk);
            held = busy;
            @(posedge clk);
        end
        while (held);
        pending_times.push_back(typed ? want : decode_time_code(x));
        codes_sent++;
    endtask

    task automatic idle_gap(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic settle_pipeline();
        start <= 1'b0;
        while (pending_times.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_epochs(input logic [31:0] tai, input logic [31:0] mission);
        logic held;
        cfg_valid <= 1'b1;
        cfg_index <= cuc_pkg::CFG_TAI_EPOCH;
        cfg_data <= tai;
        do
        begin
            @(negedge clk);
            held = !cfg_ready;
            @(posedge clk);
        end
        while (held);
        tai_offset = tai;
        cfg_index <= cuc_pkg::CFG_MISSION_EPOCH;
        cfg_data <= mission;
        do
        begin
            @(negedge clk);
            held = !cfg_ready;
            @(posedge clk);
        end
        while (held);
        mission_offset = mission;
        cfg_valid <= 1'b0;
        epoch_writes += 2;
    endtask

    // result checker
    always @(posedge clk)
    begin
        cuc_pkg::cuc_out_t want;
        if (rst_n && result_valid)
        begin
            times_checked++;
            case (result.status)
                cuc_pkg::STATUS_OK:       n_ok++;
                cuc_pkg::STATUS_INVALID:  n_invalid++;
                cuc_pkg::STATUS_MISMATCH: n_mismatch++;
                default:                  ;
            endcase
            if (pending_times.size() == 0)
            begin
                $error("unexpected result transaction: %h", result);
                fail_count++;
            end
            else
            begin
                want = pending_times.pop_front();
                if (result.seconds !== want.seconds)
                begin
                    $error("seconds: expected %h, got %h", want.seconds, result.seconds);
                    fail_count++;
                end
                if (result.microseconds !== want.microseconds)
                begin
                    $error("microseconds: expected %0d, got %0d",
                           want.microseconds, result.microseconds);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** cuc_time_code_decoder: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] tai_set [NUM_PHASES];
        logic [31:0] mission_set [NUM_PHASES];
        tai_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    cuc_pkg::TAI_EPOCH_RESET, $urandom};
        mission_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                        cuc_pkg::MISSION_EPOCH_RESET, $urandom};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed codes under the reset epoch offsets
        foreach (DIR_ROWS[i])
            issue_code(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        settle_pipeline();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_epochs(tai_set[p], mission_set[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < IDLE_PCT[p])
                    idle_gap($urandom_range(1, 6));
                else if ($urandom_range(0, 199) == 0)
                    settle_pipeline();
                issue_code(rand_time_code(), 1'b0, NO_WANT);
            end
            settle_pipeline();
        end

        start <= 1'b0;
        while (pending_times.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("coverage: %0d codes sent, %0d results checked, %0d epoch register writes",
                 codes_sent, times_checked, epoch_writes);
        $display("status mix: %0d ok, %0d invalid code, %0d p-field mismatch",
                 n_ok, n_invalid, n_mismatch);
        if (fail_count == 0)
            $display("** cuc_time_code_decoder: PASSED **");
        else
            $display("** cuc_time_code_decoder: FAILED **");
        $finish;
    end

endmodule
